// ===== rtl/six_stage_step_sequencer_defines.svh =====
// Assertion macros shared by the step sequencer RTL.
`ifndef SIX_STAGE_STEP_SEQUENCER_DEFINES_SVH
`define SIX_STAGE_STEP_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset.
`define SSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define SSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SSS_ASSERT(label, clk, rst, prop, msg)
`define SSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/sss_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and helper functions of the six-stage step sequencer.
package sss_pkg;

   localparam int NUM_STAGES      = 6;
   localparam int LEAD_IN_SAMPLES = 48;

   localparam int STAGE_W  = $clog2(NUM_STAGES);
   localparam int LED_W    = 6;
   localparam int NOTE_W   = 7;
   localparam int LEN_W    = 3;
   localparam int KNOB_W   = 12;
   localparam int PERIOD_W = 16;
   localparam int GATE_W   = 18;
   localparam int LEAD_W   = 6;
   localparam int NOISE_W  = 12;
   localparam int SEED_W   = 32;
   localparam int MODE_W   = 2;

   localparam logic [SEED_W-1:0] LCG_MUL  = 32'd1664525;
   localparam logic [SEED_W-1:0] LCG_ADD  = 32'd1013904223;
   localparam logic [SEED_W-1:0] LCG_MUL2 = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
   localparam logic [SEED_W-1:0] LCG_ADD2 = 32'(64'(LCG_MUL) * 64'(LCG_ADD) + 64'(LCG_ADD));

   localparam int NOTE_SPAN  = 72;
   localparam int MAX_LENGTH = 6;

   localparam logic [NOTE_W-1:0]   NOTE_BASE    = 7'd32;
   localparam logic [NOTE_W-1:0]   NOTE_RESET   = 7'd60;
   localparam logic [LEN_W-1:0]    LEN_RESET    = 3'd1;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(48000 / 2);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = {PERIOD_W{1'b1}};
   localparam logic [GATE_W-1:0]   SELECT_GATE  = 18'd10;
   localparam logic [NOISE_W-1:0]  HALF_CODE    = 12'd2048;
   localparam logic [LEAD_W-1:0]   LEAD_LOAD    = LEAD_W'(LEAD_IN_SAMPLES);

   typedef enum logic [MODE_W-1:0] {
      MODE_PLAY   = 2'd0,
      MODE_SELECT = 2'd1,
      MODE_EDIT   = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              clock_edge;
      logic              reset_edge;
      logic              clock_connected;
      logic [KNOB_W-1:0] knob_main;
      logic [KNOB_W-1:0] knob_x;
      logic [KNOB_W-1:0] knob_y;
   } req_type;

   typedef struct packed {
      logic [NOTE_W-1:0]         note;
      logic                      gate;
      logic [LED_W-1:0]          led_on;
      logic [LED_W-1:0]          led_dim;
      logic signed [NOISE_W-1:0] noise;
      logic signed [NOISE_W-1:0] held_random;
   } rsp_type;

   function automatic logic [LED_W-1:0] light(input logic [7:0] idx);
      logic [LED_W-1:0] bits;
      bits = '0;
      if (idx < 8'(LED_W)) begin
         bits = LED_W'(1) << idx;
      end
      return bits;
   endfunction

   function automatic logic [NOISE_W-1:0] noise_code(input logic [SEED_W-1:0] st);
      return st[SEED_W-1 -: NOISE_W] - HALF_CODE;
   endfunction

   function automatic logic [GATE_W-1:0] gate_span(input logic [LEN_W-1:0] len,
                                                   input logic [PERIOD_W-1:0] period);
      logic [GATE_W:0] prod;
      prod = (GATE_W+1)'(len) * (GATE_W+1)'(period);
      return prod[GATE_W:1];
   endfunction

endpackage

// ===== rtl/six_stage_step_sequencer.sv =====
`timescale 1ns / 1ps
// Six-stage step sequencer: one audio sample per transaction, registered single pass.
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   req_data (sss_pkg::req_type)
//   rsp_      out         rsp_valid/rsp_stall   rsp_data (sss_pkg::rsp_type)
//   csr_      in          csr_wr_en             csr_wr_data (noise seed)
//
// One transaction per cycle while rsp_stall is low; the result goes from the input register,
// through one pass of update logic, into the result register.
// The two LCG multipliers (one and two steps ahead) set the longest path.
// Synchronous reset restores all sequencer state.
// rsp_stall holds the result register; the input register keeps taking a
// transaction until it is full and cannot drain, then req_stall rises.
`include "six_stage_step_sequencer_defines.svh"

module six_stage_step_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  sss_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output sss_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [sss_pkg::SEED_W-1:0]  csr_wr_data
);
   import sss_pkg::*;

   req_type                req_ff;
   logic                   req_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   rsp_valid_ff;
   logic                   advance;

   logic [NOTE_W-1:0]      stage_note_ff [NUM_STAGES];
   logic [NOTE_W-1:0]      stage_note_in [NUM_STAGES];
   logic [LEN_W-1:0]       stage_len_ff  [NUM_STAGES];
   logic [LEN_W-1:0]       stage_len_in  [NUM_STAGES];
   logic [NUM_STAGES-1:0]  note_caught_ff, note_caught_in;
   logic [NUM_STAGES-1:0]  len_caught_ff, len_caught_in;
   logic [GATE_W-1:0]      gate_rem_ff, gate_rem_in;
   logic [LEAD_W-1:0]      lead_ff, lead_in;
   logic                   gate_level_ff, gate_level_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic [PERIOD_W-1:0]    interval_ff, interval_in;
   logic [STAGE_W-1:0]     active_ff, active_in;
   logic [LEN_W-1:0]       act_len_ff, act_len_in;
   logic [LEN_W-1:0]       clocks_ff, clocks_in;
   logic [MODE_W-1:0]      prev_mode_ff, prev_mode_in;
   logic [NOISE_W-1:0]     held_ff, held_in;
   logic [SEED_W-1:0]      noise_state_ff, noise_state_in;
   logic                   pending_ff, pending_in;

   logic [SEED_W-1:0]      lcg_one;
   logic [SEED_W-1:0]      lcg_two;
   logic [STAGE_W-1:0]     ky_stage;
   logic [STAGE_W-1:0]     next_stage;
   logic [STAGE_W-1:0]     note_addr;
   logic [STAGE_W-1:0]     len_addr;
   logic [NOTE_W-1:0]      note_rd;
   logic [LEN_W-1:0]       len_rd;
   logic [NOTE_W-1:0]      knote;
   logic [LEN_W-1:0]       klen;
   logic [GATE_W-1:0]      rem_base;
   logic [GATE_W-1:0]      tick_rem;
   logic [LEAD_W-1:0]      tick_lead;
   logic                   tick_level;
   logic                   restart_now;
   logic                   clock_hit;
   logic                   edit_entry;
   logic                   nc;
   logic                   lc;
   logic [NOTE_W-1:0]      note_new;
   logic [LEN_W-1:0]       len_new;
   logic [LED_W-1:0]       led_on;
   logic [LED_W-1:0]       led_dim;
   logic [7:0]             dim_mask;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign lcg_one = LCG_MUL * noise_state_ff + LCG_ADD;
   assign lcg_two = LCG_MUL2 * noise_state_ff + LCG_ADD2;

   assign ky_stage   = STAGE_W'((32'(req_ff.knob_y) * 32'(NUM_STAGES)) >> KNOB_W);
   assign next_stage = (active_ff == STAGE_W'(NUM_STAGES - 1)) ? '0
                                                             : active_ff + STAGE_W'(1);
   assign note_addr  = (req_ff.mode == MODE_SELECT) ? ky_stage : active_ff;
   assign len_addr   = (req_ff.mode == MODE_SELECT) ? ky_stage : next_stage;
   assign note_rd    = stage_note_ff[note_addr];
   assign len_rd     = stage_len_ff[len_addr];

   assign knote = NOTE_BASE + NOTE_W'((32'(req_ff.knob_main) * 32'(NOTE_SPAN)) >> KNOB_W);
   assign klen  = LEN_W'(((32'(req_ff.knob_x) * 32'(MAX_LENGTH)) >> KNOB_W) + 32'd1);

   // gate tick
   always_comb begin
      rem_base = (req_ff.mode == MODE_SELECT) ? SELECT_GATE : gate_rem_ff;
      if (lead_ff == '0 && rem_base != '0) begin
         tick_rem   = rem_base - GATE_W'(1);
         tick_lead  = lead_ff;
         tick_level = 1'b1;
      end else begin
         tick_rem   = rem_base;
         tick_lead  = (lead_ff != '0) ? lead_ff - LEAD_W'(1) : lead_ff;
         tick_level = 1'b0;
      end
   end

   assign restart_now = pending_ff || req_ff.reset_edge;
   assign clock_hit   = req_ff.clock_edge ||
                        (!req_ff.clock_connected && interval_ff >= period_ff);
   assign edit_entry  = prev_mode_ff != MODE_EDIT;
   assign nc       = (!edit_entry && note_caught_ff[active_ff]) || (note_rd == knote);
   assign lc       = (!edit_entry && len_caught_ff[active_ff]) || (act_len_ff == klen);
   assign note_new = nc ? knote : note_rd;
   assign len_new  = lc ? klen : act_len_ff;
   assign dim_mask = (8'd1 << len_new) - 8'd1;

   always_comb begin
      stage_note_in  = stage_note_ff;
      stage_len_in   = stage_len_ff;
      note_caught_in = note_caught_ff;
      len_caught_in  = len_caught_ff;
      gate_rem_in    = gate_rem_ff;
      lead_in        = lead_ff;
      gate_level_in  = gate_level_ff;
      period_in      = period_ff;
      interval_in    = interval_ff;
      active_in      = active_ff;
      act_len_in     = act_len_ff;
      clocks_in      = clocks_ff;
      held_in        = held_ff;
      noise_state_in = lcg_one;
      pending_in     = pending_ff;
      prev_mode_in   = req_ff.mode;
      led_on         = '0;
      led_dim        = '0;
      rsp_in.note    = note_rd;

      case (req_ff.mode)
         MODE_PLAY: begin
            pending_in    = restart_now;
            gate_rem_in   = tick_rem;
            lead_in       = tick_lead;
            gate_level_in = tick_level;
            if (tick_rem != '0) begin
               led_on = light(8'(active_ff));
            end
            if (clock_hit) begin
               period_in   = interval_ff;
               interval_in = '0;
               if (restart_now) begin
                  active_in      = '0;
                  clocks_in      = '0;
                  lead_in        = LEAD_LOAD;
                  gate_level_in  = 1'b0;
                  gate_rem_in    = gate_span(stage_len_ff[0], interval_ff);
                  act_len_in     = stage_len_ff[0];
                  held_in        = noise_code(lcg_two);
                  noise_state_in = lcg_two;
                  pending_in     = 1'b0;
               end else if ((4'(clocks_ff) + 4'd1) >= 4'(act_len_ff)) begin
                  clocks_in      = '0;
                  active_in      = next_stage;
                  gate_rem_in    = gate_span(len_rd, interval_ff);
                  act_len_in     = len_rd;
                  held_in        = noise_code(lcg_two);
                  noise_state_in = lcg_two;
               end else begin
                  clocks_in = clocks_ff + LEN_W'(1);
               end
            end else if (interval_ff != PERIOD_MAX) begin
               interval_in = interval_ff + PERIOD_W'(1);
            end
         end
         MODE_SELECT: begin
            gate_rem_in   = tick_rem;
            lead_in       = tick_lead;
            gate_level_in = tick_level;
            active_in     = ky_stage;
            act_len_in    = len_rd;
            led_on        = light(8'(ky_stage));
         end
         MODE_EDIT: begin
            stage_note_in[active_ff]  = note_new;
            stage_len_in[active_ff]   = len_new;
            note_caught_in[active_ff] = nc;
            len_caught_in[active_ff]  = lc;
            act_len_in                = len_new;
            if (nc) begin
               led_on = light(8'd0);
            end
            if (lc && len_new != '0) begin
               led_on = led_on | light(8'(len_new) - 8'd1);
            end
            led_dim     = dim_mask[LED_W-1:0] & ~led_on;
            rsp_in.note = note_new;
         end
         default: begin
         end
      endcase

      rsp_in.gate        = gate_level_in;
      rsp_in.led_on      = led_on;
      rsp_in.led_dim     = led_dim;
      rsp_in.noise       = $signed(noise_code(lcg_one));
      rsp_in.held_random = $signed(held_ff);
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_STAGES; i++) begin
            stage_note_ff[i] <= NOTE_RESET;
            stage_len_ff[i]  <= LEN_RESET;
         end
         note_caught_ff <= '0;
         len_caught_ff  <= '0;
         gate_rem_ff    <= '0;
         lead_ff        <= '0;
         gate_level_ff  <= 1'b0;
         period_ff      <= PERIOD_RESET;
         interval_ff    <= '0;
         active_ff      <= '0;
         act_len_ff     <= LEN_RESET;
         clocks_ff      <= '0;
         prev_mode_ff   <= MODE_PLAY;
         held_ff        <= '0;
         noise_state_ff <= '0;
         pending_ff     <= 1'b1;
      end else begin
         if (req_valid && !req_stall) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            stage_note_ff  <= stage_note_in;
            stage_len_ff   <= stage_len_in;
            note_caught_ff <= note_caught_in;
            len_caught_ff  <= len_caught_in;
            gate_rem_ff    <= gate_rem_in;
            lead_ff        <= lead_in;
            gate_level_ff  <= gate_level_in;
            period_ff      <= period_in;
            interval_ff    <= interval_in;
            active_ff      <= active_in;
            act_len_ff     <= act_len_in;
            clocks_ff      <= clocks_in;
            prev_mode_ff   <= prev_mode_in;
            held_ff        <= held_in;
            pending_ff     <= pending_in;
         end
         if (csr_wr_en) begin
            noise_state_ff <= csr_wr_data;
         end else if (advance) begin
            noise_state_ff <= noise_state_in;
         end
      end
   end

   `SSS_ASSERT(a_act_len_mirror, clock, reset, act_len_ff == stage_len_ff[active_ff], "active length copy out of step")
   `SSS_ASSERT(a_lead_in_gate_low, clock, reset, (lead_ff != '0) |-> !gate_level_ff, "gate high during lead-in")
   `SSS_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff, "result register not filled")
   `SSS_ASSERT(a_restart_on_advance, clock, reset, $fell(pending_ff) |-> $past(advance), "restart cleared without a transaction")

endmodule
